@@ rtl/mrc_pkg.sv @@
// Package: shared types, constants and the CRC-16 byte update for the request checker.
`timescale 1ns / 1ps
package mrc_pkg;

  localparam int unsigned FrameBytes = 8;
  localparam int unsigned CrcBytes   = 6;
  localparam logic [3:0]  CountMax   = 4'd15;

  localparam logic [15:0] CrcInit    = 16'hFFFF;
  localparam logic [15:0] CrcPoly    = 16'hA001;

  localparam logic [7:0]  FuncReadHolding = 8'h03;
  localparam logic [7:0]  FuncWriteSingle = 8'h06;

  localparam logic [7:0]  LocalAddrReset  = 8'd2;

  typedef enum logic [2:0] {
    STATUS_OK       = 3'd0,
    STATUS_ADDRESS  = 3'd1,
    STATUS_FUNCTION = 3'd2,
    STATUS_LENGTH   = 3'd3,
    STATUS_CRC      = 3'd4
  } status_e;

  // First member sits in the top bits, so status ends up in the lowest bits.
  typedef struct packed {
    logic [15:0] register_data;
    logic [15:0] register_address;
    logic [7:0]  function_code;
    status_e     status;
  } result_t;

  localparam int unsigned ResultBits = $bits(result_t);
  localparam int unsigned OutBytes   = (ResultBits + 7) / 8;

  // Reflected CRC-16, one byte, eight shift steps unrolled.
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/mrc_frame_core.sv @@
// Frame state (byte count, running CRC, byte store) and the end-of-frame checks.
`timescale 1ns / 1ps
module mrc_frame_core
  import mrc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       advance_i,
  input  logic [7:0] rx_byte_i,
  input  logic       frame_last_i,
  input  logic [7:0] local_address_i,
  output result_t    result_o
);

  logic [3:0]  count_q, count_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  store_q [FrameBytes];
  logic [7:0]  store_new [FrameBytes];
  logic [7:0]  frame_byte [FrameBytes];
  logic [3:0]  len;
  logic [15:0] crc_new;
  logic [15:0] crc_rcv;

  always_comb begin
    for (int p = 0; p < FrameBytes; p++) begin
      store_new[p] = store_q[p];
    end
    if (count_q < 4'(FrameBytes)) begin
      store_new[count_q[2:0]] = rx_byte_i;
    end

    crc_new = (count_q < 4'(CrcBytes)) ? crc16_byte(crc_q, rx_byte_i) : crc_q;
    len     = (count_q < CountMax) ? count_q + 4'd1 : CountMax;

    // positions the frame never reached read as zero
    for (int p = 0; p < FrameBytes; p++) begin
      frame_byte[p] = (4'(p) < len) ? store_new[p] : 8'h00;
    end
    crc_rcv = {frame_byte[7], frame_byte[6]};

    result_o.function_code    = frame_byte[1];
    result_o.register_address = {frame_byte[2], frame_byte[3]};
    result_o.register_data    = {frame_byte[4], frame_byte[5]};
    priority if (frame_byte[0] != local_address_i) begin
      result_o.status = STATUS_ADDRESS;
    end else if (frame_byte[1] != FuncReadHolding && frame_byte[1] != FuncWriteSingle) begin
      result_o.status = STATUS_FUNCTION;
    end else if (len != 4'(FrameBytes)) begin
      result_o.status = STATUS_LENGTH;
    end else if (crc_rcv != crc_new) begin
      result_o.status = STATUS_CRC;
    end else begin
      result_o.status = STATUS_OK;
    end

    count_d = count_q;
    crc_d   = crc_q;
    if (advance_i) begin
      count_d = frame_last_i ? 4'd0 : len;
      crc_d   = frame_last_i ? CrcInit : crc_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 4'd0;
      crc_q   <= CrcInit;
    end else begin
      count_q <= count_d;
      crc_q   <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      for (int p = 0; p < FrameBytes; p++) begin
        store_q[p] <= store_new[p];
      end
    end
  end

  // a marked byte always restarts the frame
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && frame_last_i |=> count_q == 4'd0 && crc_q == CrcInit)
    else $error("frame state not restarted after last byte");

  // the count only moves on an advancing item
  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance_i |=> $stable(count_q) && $stable(crc_q))
    else $error("frame state moved without an item");

  // the count saturates and never wraps
  a_count_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && !frame_last_i && count_q == CountMax |=> count_q == CountMax)
    else $error("byte count wrapped");

endmodule

@@ rtl/modbus_rtu_request_checker.sv @@
// Top level: Modbus RTU request checker with byte input stream and result stream.
//
// Input stream: one frame byte per item on s_axis_tdata, s_axis_tlast marks
// the final byte of a request frame. Output stream: one result item per
// frame, sent after the marked byte: status, function code, register address
// and register data (count or write value). Fields other than status carry
// the received bytes (zero where the frame was short) whatever the status.
// cfg_we_i/cfg_data_i write the local slave address (reset value 2).
//
// Timing: a byte is taken into an input register, processed by the CRC and
// check logic and, for a marked byte, the result lands in the output register.
// One item per cycle is sustained while no marked byte waits on the output;
// the single output register limits overlap, so a marked byte waits in the
// input register while an earlier result is still held.
// A stalled receiver holds the result and, once a marked byte is waiting,
// deasserts s_axis_tready; unmarked bytes keep flowing.
// Reset clears the frame count, the CRC and both valid flags; the block is
// ready as soon as reset is released.
`timescale 1ns / 1ps
module modbus_rtu_request_checker
  import mrc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [7:0]              cfg_data_i,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [7:0]              s_axis_tdata,  // [7:0] rx_byte
  input  logic                    s_axis_tlast,  // frame_last
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // [2:0] status, [10:3] function_code, [26:11] register_address,
  // [42:27] register_data, [47:43] zero
  output logic [8*OutBytes-1:0]   m_axis_tdata
);

  logic [7:0] local_addr_q;
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       advance;
  logic       in_take;
  logic       out_valid_q, out_valid_d;
  result_t    result_q;
  result_t    core_result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_addr_q <= LocalAddrReset;
    end else if (cfg_we_i) begin
      local_addr_q <= cfg_data_i;
    end
  end

  // a marked byte may only move on when the output register is free or its result is being taken
  assign advance       = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_q);
    if (advance && in_last_q) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (advance && in_last_q) begin
      result_q <= core_result;
    end
  end

  mrc_frame_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .advance_i       (advance),
    .rx_byte_i       (in_byte_q),
    .frame_last_i    (in_last_q),
    .local_address_i (local_addr_q),
    .result_o        (core_result)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(8*OutBytes-ResultBits){1'b0}}, result_q};

  // results appear only from a marked byte leaving the input register
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(advance && in_last_q))
    else $error("result without a marked byte");

  // a held result never gets overwritten by the next frame
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |-> !(advance && in_last_q))
    else $error("result overwritten while stalled");

  // unmarked bytes never wait on the output side
  a_bytes_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !in_last_q |-> advance && s_axis_tready)
    else $error("unmarked byte stalled");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> result_q.status <= STATUS_CRC)
    else $error("status out of range");

endmodule

@@ tb/sv/testbench.sv @@
// Testbench: drives Modbus RTU request frames into the checker and compares every result.
`timescale 1ns / 1ps
module testbench;
  import mrc_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned PhaseItems  = 105;
  localparam int unsigned NumPhases   = 6;
  localparam int unsigned OutW        = 8 * OutBytes;

  typedef enum logic [1:0] {
    SRC_LITERAL,
    SRC_CRC_LO,
    SRC_CRC_HI
  } byte_src_e;

  typedef struct packed {
    byte_src_e   src;
    logic [7:0]  data;
    logic        last;
    logic        typed;
    status_e     stat;
    logic [7:0]  fc;
    logic [15:0] addr;
    logic [15:0] dat;
  } frame_row_t;

  // Directed frames, local address at its reset value.
  // CRC rows are filled in from the bytes sent so far in the frame.
  localparam frame_row_t DirectedRows [25] = '{
    // one byte, own address: function reads as zero
    '{SRC_LITERAL, 8'h02, 1'b1, 1'b1, STATUS_FUNCTION, 8'h00, 16'h0000, 16'h0000},
    // one byte, foreign address
    '{SRC_LITERAL, 8'hFF, 1'b1, 1'b1, STATUS_ADDRESS, 8'h00, 16'h0000, 16'h0000},
    // unsupported function
    '{SRC_LITERAL, 8'h02, 1'b0, 1'b0, STATUS_OK, 8'h00, 16'h0000, 16'h0000},
    '{SRC_LITERAL, 8'hFF, 1'b1, 1'b1, STATUS_FUNCTION, 8'hFF, 16'h0000, 16'h0000},
    // well-formed read holding registers
    '{SRC_LITERAL, 8'h02, 1'b0, 1'b0, STATUS_OK, 8'h00, 16'h0000, 16'h0000},
    '{SRC_LITERAL, 8'h03, 1'b0, 1'b0, STATUS_OK, 8'h00, 16'h0000, 16'h0000},
    '{SRC_LITERAL, 8'h00, 1'b0, 1'b0, STATUS_OK, 8'h00, 16'h0000, 16'h0000},
    '{SRC_LITERAL, 8'h00, 1'b0, 1'b0, STATUS_OK, 8'h00, 16'h0000, 16'h0000},
    '{SRC_LITERAL, 8'h00, 1'b0, 1'b0, STATUS_OK, 8'h00, 16'h0000, 16'h0000},
    '{SRC_LITERAL, 8'h00, 1'b0, 1'b0, STATUS_OK, 8'h00, 16'h0000, 16'h0000},
    '{SRC_CRC_LO,  8'h00, 1'b0, 1'b0, STATUS_OK, 8'h00, 16'h0000, 16'h0000},
    '{SRC_CRC_HI,  8'h00, 1'b1, 1'b0, STATUS_OK, 8'h00, 16'h0000, 16'h0000},
    // short write: missing bytes read as zero
    '{SRC_LITERAL, 8'h02, 1'b0, 1'b0, STATUS_OK, 8'h00, 16'h0000, 16'h0000},
    '{SRC_LITERAL, 8'h06, 1'b0, 1'b0, STATUS_OK, 8'h00, 16'h0000, 16'h0000},
    '{SRC_LITERAL, 8'hAB, 1'b1, 1'b1, STATUS_LENGTH, 8'h06, 16'hAB00, 16'h0000},
    // long write with valid CRC in place: extra bytes ignored, still bad length
    '{SRC_LITERAL, 8'h02, 1'b0, 1'b0, STATUS_OK, 8'h00, 16'h0000, 16'h0000},
    '{SRC_LITERAL, 8'h06, 1'b0, 1'b0, STATUS_OK, 8'h00, 16'h0000, 16'h0000},
    '{SRC_LITERAL, 8'hFF, 1'b0, 1'b0, STATUS_OK, 8'h00, 16'h0000, 16'h0000},
    '{SRC_LITERAL, 8'hFF, 1'b0, 1'b0, STATUS_OK, 8'h00, 16'h0000, 16'h0000},
    '{SRC_LITERAL, 8'hFF, 1'b0, 1'b0, STATUS_OK, 8'h00, 16'h0000, 16'h0000},
    '{SRC_LITERAL, 8'hFF, 1'b0, 1'b0, STATUS_OK, 8'h00, 16'h0000, 16'h0000},
    '{SRC_CRC_LO,  8'h00, 1'b0, 1'b0, STATUS_OK, 8'h00, 16'h0000, 16'h0000},
    '{SRC_CRC_HI,  8'h00, 1'b0, 1'b0, STATUS_OK, 8'h00, 16'h0000, 16'h0000},
    '{SRC_LITERAL, 8'h55, 1'b0, 1'b0, STATUS_OK, 8'h00, 16'h0000, 16'h0000},
    '{SRC_LITERAL, 8'hAA, 1'b1, 1'b1, STATUS_LENGTH, 8'h06, 16'hFFFF, 16'hFFFF}
  };

  logic            clk_i    = 1'b0;
  logic            rst_ni   = 1'b0;
  logic            cfg_we   = 1'b0;
  logic [7:0]      cfg_data = 8'h00;
  logic            s_valid  = 1'b0;
  logic            s_ready;
  logic [7:0]      s_data   = 8'h00;
  logic            s_last   = 1'b0;
  logic            m_valid;
  logic            m_ready  = 1'b0;
  logic [OutW-1:0] m_data;

  // checker copy of the block state
  logic [7:0]  slave_addr = LocalAddrReset;
  logic [3:0]  frame_len  = 4'd0;
  logic [15:0] frame_crc  = CrcInit;
  logic [7:0]  frame_bytes [FrameBytes];

  result_t     pending_results [$];
  int unsigned errors      = 0;
  int unsigned items_sent  = 0;
  int unsigned cycle_count = 0;
  bit          tx_idle_on  = 1'b1;
  bit          rx_idle_on  = 1'b1;
  bit          hold_req    = 1'b0;
  result_t     got, want;

  modbus_rtu_request_checker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("modbus_rtu_request_checker regression: fail");
      $finish;
    end
  end

  function automatic logic [15:0] crc_next(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    return c;
  endfunction

  // bytes past the end of the frame read as zero
  function automatic logic [7:0] frame_byte(int unsigned pos, int unsigned len);
    return (pos < len && pos < FrameBytes) ? frame_bytes[pos[2:0]] : 8'h00;
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic take_byte(input logic [7:0] b, input logic last, output logic done,
                           output result_t r);
    int unsigned len;
    logic [15:0] rcv_crc;
    done = 1'b0;
    r    = '0;
    if (frame_len < FrameBytes) frame_bytes[frame_len[2:0]] = b;
    if (frame_len < CrcBytes) frame_crc = crc_next(frame_crc, b);
    if (frame_len < CountMax) frame_len = frame_len + 4'd1;
    if (last) begin
      len                = frame_len;
      r.function_code    = frame_byte(1, len);
      r.register_address = {frame_byte(2, len), frame_byte(3, len)};
      r.register_data    = {frame_byte(4, len), frame_byte(5, len)};
      rcv_crc            = {frame_byte(7, len), frame_byte(6, len)};
      if (frame_byte(0, len) != slave_addr) begin
        r.status = STATUS_ADDRESS;
      end else if (r.function_code != FuncReadHolding &&
                   r.function_code != FuncWriteSingle) begin
        r.status = STATUS_FUNCTION;
      end else if (len != FrameBytes) begin
        r.status = STATUS_LENGTH;
      end else if (rcv_crc != frame_crc) begin
        r.status = STATUS_CRC;
      end else begin
        r.status = STATUS_OK;
      end
      frame_len = 4'd0;
      frame_crc = CrcInit;
      done      = 1'b1;
    end
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                           input result_t typed_res);
    logic    done;
    result_t r;
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    s_last  <= last;
    do @(posedge clk_i); while (!s_ready);
    take_byte(b, last, done, r);
    if (done) pending_results.push_back(typed ? typed_res : r);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic random_frame();
    logic [7:0]  fr [$];
    logic [15:0] crc;
    int unsigned kind;
    kind = $urandom_range(0, 99);
    crc  = CrcInit;
    if (kind < 85) begin
      fr.push_back($urandom_range(0, 7) == 0 ? rand_byte() : slave_addr);
      fr.push_back($urandom_range(0, 9) == 0 ? rand_byte() :
                   ($urandom_range(0, 1) ? FuncReadHolding : FuncWriteSingle));
      repeat (4) fr.push_back(rand_byte());
      foreach (fr[i]) crc = crc_next(crc, fr[i]);
      if ($urandom_range(0, 7) == 0) crc ^= 16'(1 << $urandom_range(0, 15));
      fr.push_back(crc[7:0]);
      fr.push_back(crc[15:8]);
      if (kind >= 75) begin
        repeat ($urandom_range(1, 8)) fr.push_back(rand_byte());
      end else if (kind >= 60) begin
        fr = fr[0:$urandom_range(0, 6)];
      end
    end else begin
      repeat ($urandom_range(1, 12)) fr.push_back(rand_byte());
    end
    foreach (fr[i]) send_byte(fr[i], i == fr.size() - 1, 1'b0, '0);
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_slave_addr(input logic [7:0] addr);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= addr;
    @(negedge clk_i);
    cfg_we     <= 1'b0;
    slave_addr  = addr;
  endtask

  // result side: random stalls, plus one long hold so the input backs up
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_ready <= 1'b0;
        hold_req = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(0, 15)) @(negedge clk_i);
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready) begin
      got = result_t'(m_data[ResultBits-1:0]);
      if (pending_results.size() == 0) begin
        $display("%0t: result expected none got status %0d fc %02h addr %04h data %04h",
                 $time, got.status, got.function_code, got.register_address,
                 got.register_data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
          errors++;
        end
        if (got.function_code !== want.function_code) begin
          $display("%0t: function code expected %02h got %02h", $time,
                   want.function_code, got.function_code);
          errors++;
        end
        if (got.register_address !== want.register_address) begin
          $display("%0t: register address expected %04h got %04h", $time,
                   want.register_address, got.register_address);
          errors++;
        end
        if (got.register_data !== want.register_data) begin
          $display("%0t: register data expected %04h got %04h", $time,
                   want.register_data, got.register_data);
          errors++;
        end
      end
    end
  end

  initial begin
    frame_row_t  row;
    result_t     typed_res;
    logic [15:0] dir_crc;
    int unsigned pos;
    int unsigned phase_start;
    logic [7:0]  addr;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    dir_crc = CrcInit;
    pos     = 0;
    foreach (DirectedRows[i]) begin
      row = DirectedRows[i];
      case (row.src)
        SRC_CRC_LO: row.data = dir_crc[7:0];
        SRC_CRC_HI: row.data = dir_crc[15:8];
        default: ;
      endcase
      if (pos < CrcBytes) dir_crc = crc_next(dir_crc, row.data);
      pos++;
      if (row.last) begin
        pos     = 0;
        dir_crc = CrcInit;
      end
      typed_res                  = '0;
      typed_res.status           = row.stat;
      typed_res.function_code    = row.fc;
      typed_res.register_address = row.addr;
      typed_res.register_data    = row.dat;
      send_byte(row.data, row.last, row.typed, typed_res);
    end
    s_valid <= 1'b0;

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: addr = 8'h00;
        1: addr = 8'hFF;
        default: addr = 8'($urandom_range(0, 255));
      endcase
      write_slave_addr(addr);
      // middle phase runs the receiver flat out, last phase has no gaps at all
      tx_idle_on = (p < NumPhases - 1);
      rx_idle_on = (p != 3) && (p < NumPhases - 1);
      if (p == 1) hold_req = 1'b1;
      phase_start = items_sent;
      while (items_sent - phase_start < PhaseItems) random_frame();
      s_valid <= 1'b0;
    end

    drain();
    if (errors == 0) begin
      $display("modbus_rtu_request_checker regression: pass");
    end else begin
      $display("modbus_rtu_request_checker regression: fail");
    end
    $finish;
  end

endmodule
